### hw/rtl/msva_pkg.sv
// ----------------------------------------------------------------------------
// msva_pkg: shared types and constants of the mesh signed volume accumulator
// Field widths, the queue item between front and back, the matrix register
// set, register index codes and the divide-by-six digit step.
// ----------------------------------------------------------------------------
package msva_pkg;

    localparam int COORD_W       = 20;   // width of a vertex coordinate port
    localparam int NUM_COORDS    = 9;    // A, B and C, three axes each
    localparam int NORM_W        = 16;   // one packed Q1.14 or Q2.14 lane
    localparam int ROW_W         = 48;   // three packed lanes
    localparam int SUM_W         = 64;   // running sum and result width
    localparam int TERM_W        = 63;   // magnitude term, never above 2^63-1
    localparam int OUT_FRAC      = 24;   // fraction bits of the sum
    localparam int VOLUME_DIV    = 6;    // the sum holds six times the volume
    localparam int OCTET_W       = 8;    // quotient digit taken per stage
    localparam int REM_W         = 3;    // remainder of a divide by six
    localparam int DIV_STAGES    = SUM_W / OCTET_W;
    localparam int FRONT_STAGES  = 5;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = 3;
    localparam int CFG_IDX_W     = 2;

    localparam logic [ROW_W-1:0] MATRIX_RESET = 48'h0000_4000_4000;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TWO  = 2'd2;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        t_row row_two;
        t_row row_one;
        t_row row_zero;
    } t_matrix;

    typedef struct packed {
        logic                                first;
        logic [NUM_COORDS-1:0][COORD_W-1:0] coord;   // ax ay az bx by bz cx cy cz
        logic [ROW_W-1:0]                    normal;
    } t_triangle;

    typedef struct packed {
        logic              first;   // clear the sum before this term
        logic              sub;     // subtract rather than add
        logic              clip;    // the term itself was clamped
        logic [TERM_W-1:0] term;
    } t_term_item;

    typedef struct packed {
        logic               empty;
        logic [FIFO_AW:0]   count;
    } t_fifo_status;

    // One long-division digit by six: remainder in, eight dividend bits in,
    // eight quotient bits and the new remainder out.
    function automatic logic [OCTET_W+REM_W-1:0] div6_octet(
        input logic [REM_W-1:0]   rem_in,
        input logic [OCTET_W-1:0] octet_in
    );
        logic [REM_W:0]     acc;
        logic [REM_W-1:0]   rem;
        logic [OCTET_W-1:0] quo;
        rem = rem_in;
        quo = '0;
        for (int i = OCTET_W - 1; i >= 0; i--) begin
            acc = {rem, octet_in[i]};
            if (acc >= (REM_W+1)'(VOLUME_DIV)) begin
                quo[i] = 1'b1;
                acc    = acc - (REM_W+1)'(VOLUME_DIV);
            end
            rem = acc[REM_W-1:0];
        end
        return {quo, rem};
    endfunction

endpackage

### hw/rtl/msva_fifo.sv
// ----------------------------------------------------------------------------
// msva_fifo: term queue between front and back
// A small register queue of classified terms. The front never pushes into a
// full queue because it reserves room before it accepts an item.
// ----------------------------------------------------------------------------
module msva_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  msva_pkg::t_term_item  i_push_item,
    input  logic                  i_pop,
    output msva_pkg::t_term_item  o_head,
    output msva_pkg::t_fifo_status o_status
);
    import msva_pkg::*;

    t_term_item           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic [FIFO_AW:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

### hw/rtl/msva_front.sv
// ----------------------------------------------------------------------------
// msva_front: triangle intake and classification
// Five pipeline stages form the determinant magnitude, scale it to the sum's
// fraction bits and decide from the transformed normal whether to add or
// subtract. Items are accepted only while the queue has room for them.
// ----------------------------------------------------------------------------
module msva_front #(
    parameter int COORD_BITS          = 20,
    parameter int COORD_FRACTION_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  msva_pkg::t_matrix      i_matrix,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  msva_pkg::t_triangle    i_tri,
    input  msva_pkg::t_fifo_status i_fifo_status,
    output logic                   o_push,
    output msva_pkg::t_term_item   o_push_item
);
    import msva_pkg::*;

    localparam int PAD    = COORD_W - COORD_BITS;
    localparam int D_W    = COORD_W + 1;          // vertex differences
    localparam int S_W    = COORD_W + 2;          // A+B+C
    localparam int P_W    = 2 * D_W;              // cofactor products
    localparam int C_W    = P_W + 1;              // cofactors
    localparam int DP_W   = D_W + C_W;            // determinant terms
    localparam int DET_W  = DP_W + 2;
    localparam int NP_W   = 2 * NORM_W;           // normal by matrix products
    localparam int NT_W   = NP_W + 2;             // transformed normal
    localparam int SP_W   = NT_W + S_W;
    localparam int DOT_W  = SP_W + 2;
    localparam int FRAC3  = 3 * COORD_FRACTION_BITS;
    localparam int RSH    = (FRAC3 >= OUT_FRAC) ? (FRAC3 - OUT_FRAC) : 0;
    localparam int LSH    = (FRAC3 <  OUT_FRAC) ? (OUT_FRAC - FRAC3) : 0;

    logic                    n_accept;
    logic [FIFO_AW:0]        n_inflight;
    logic [FIFO_AW+1:0]      n_load;
    logic [FRONT_STAGES-1:0] r_valid;

    // stage 1
    t_triangle               r_s1_tri;
    // stage 2
    logic                    r_s2_first;
    logic signed [D_W-1:0]   r_s2_v1 [3];
    logic signed [D_W-1:0]   r_s2_v2 [3];
    logic signed [D_W-1:0]   r_s2_v3 [3];
    logic signed [S_W-1:0]   r_s2_s  [3];
    logic signed [NP_W-1:0]  r_s2_np [3][3];
    // stage 3
    logic                    r_s3_first;
    logic signed [P_W-1:0]   r_s3_pa [3];
    logic signed [P_W-1:0]   r_s3_pb [3];
    logic signed [NT_W-1:0]  r_s3_nt [3];
    logic signed [D_W-1:0]   r_s3_v1 [3];
    logic signed [S_W-1:0]   r_s3_s  [3];
    // stage 4
    logic                    r_s4_first;
    logic signed [DP_W-1:0]  r_s4_dp [3];
    logic signed [SP_W-1:0]  r_s4_sp [3];
    // stage 5
    logic                    r_s5_first;
    logic signed [DET_W-1:0] r_s5_det;
    logic                    r_s5_neg;

    logic [COORD_W-1:0]        n_shift [NUM_COORDS];
    logic signed [COORD_W-1:0] n_p     [NUM_COORDS];
    logic signed [D_W-1:0]     n_v1    [3];
    logic signed [D_W-1:0]     n_v2    [3];
    logic signed [D_W-1:0]     n_v3    [3];
    logic signed [S_W-1:0]     n_s     [3];
    logic signed [NORM_W-1:0]  n_nl    [3];
    logic signed [NORM_W-1:0]  n_ml    [3][3];
    logic signed [NP_W-1:0]    n_np    [3][3];
    t_row                      w_rows  [3];
    logic signed [P_W-1:0]     n_pa    [3];
    logic signed [P_W-1:0]     n_pb    [3];
    logic signed [NT_W-1:0]    n_nt    [3];
    logic signed [C_W-1:0]     n_cof   [3];
    logic signed [DP_W-1:0]    n_dp    [3];
    logic signed [SP_W-1:0]    n_sp    [3];
    logic signed [DET_W-1:0]   n_det;
    logic signed [DOT_W-1:0]   n_dot;
    logic [DET_W-1:0]          n_abs;
    logic [SUM_W-1:0]          n_mag;
    logic                      n_over;
    logic [TERM_W-1:0]         n_term;

    // Room is reserved for every item in flight, so the pipeline never halts.
    assign n_inflight = (FIFO_AW+1)'($countones(r_valid));
    assign n_load     = {1'b0, i_fifo_status.count} + {1'b0, n_inflight};
    assign o_in_stall = (n_load >= (FIFO_AW+2)'(FIFO_DEPTH));
    assign n_accept   = i_in_valid && !o_in_stall;

    assign w_rows[0] = i_matrix.row_zero;
    assign w_rows[1] = i_matrix.row_one;
    assign w_rows[2] = i_matrix.row_two;

    // Stage 2: narrow coordinates, vertex differences, matrix lane products.
    always_comb begin
        for (int i = 0; i < NUM_COORDS; i++) begin
            n_shift[i] = r_s1_tri.coord[i] << PAD;
            n_p[i]     = $signed(n_shift[i]) >>> PAD;
        end
        for (int i = 0; i < 3; i++) begin
            n_v1[i] = D_W'(n_p[3+i]) - D_W'(n_p[i]);
            n_v2[i] = D_W'(n_p[6+i]) - D_W'(n_p[i]);
            n_v3[i] = -D_W'(n_p[i]);
            n_s[i]  = S_W'(n_p[i]) + S_W'(n_p[3+i]) + S_W'(n_p[6+i]);
            n_nl[i] = $signed(r_s1_tri.normal[NORM_W*i +: NORM_W]);
            for (int j = 0; j < 3; j++) begin
                n_ml[i][j] = $signed(w_rows[i][NORM_W*j +: NORM_W]);
                n_np[i][j] = NP_W'(n_nl[i]) * NP_W'(n_ml[i][j]);
            end
        end
    end

    // Stage 3: cofactor products and the transformed normal.
    always_comb begin
        n_pa[0] = P_W'(r_s2_v2[1]) * P_W'(r_s2_v3[2]);
        n_pb[0] = P_W'(r_s2_v3[1]) * P_W'(r_s2_v2[2]);
        n_pa[1] = P_W'(r_s2_v2[0]) * P_W'(r_s2_v3[2]);
        n_pb[1] = P_W'(r_s2_v3[0]) * P_W'(r_s2_v2[2]);
        n_pa[2] = P_W'(r_s2_v2[0]) * P_W'(r_s2_v3[1]);
        n_pb[2] = P_W'(r_s2_v3[0]) * P_W'(r_s2_v2[1]);
        for (int j = 0; j < 3; j++) begin
            n_nt[j] = NT_W'(r_s2_np[0][j]) + NT_W'(r_s2_np[1][j]) + NT_W'(r_s2_np[2][j]);
        end
    end

    // Stage 4: determinant terms and the sign test products.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cof[k] = C_W'(r_s3_pa[k]) - C_W'(r_s3_pb[k]);
            n_dp[k]  = DP_W'(r_s3_v1[k]) * DP_W'(n_cof[k]);
            n_sp[k]  = SP_W'(r_s3_nt[k]) * SP_W'(r_s3_s[k]);
        end
    end

    // Stage 5: determinant and dot product sums.
    assign n_det = DET_W'(r_s4_dp[0]) - DET_W'(r_s4_dp[1]) + DET_W'(r_s4_dp[2]);
    assign n_dot = DOT_W'(r_s4_sp[0]) + DOT_W'(r_s4_sp[1]) + DOT_W'(r_s4_sp[2]);

    // Magnitude and scaling to the sum's fraction bits; a left shift that
    // would overflow clamps to the largest positive value.
    always_comb begin
        n_abs  = r_s5_det[DET_W-1] ? DET_W'(-r_s5_det) : DET_W'(r_s5_det);
        n_mag  = n_abs[SUM_W-1:0];
        n_over = ((n_mag >> (SUM_W - 1 - LSH)) != '0);
        n_term = n_over ? '1 : TERM_W'((n_mag >> RSH) << LSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[FRONT_STAGES-2:0], n_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tri   <= i_tri;
        r_s2_first <= r_s1_tri.first;
        r_s2_v1    <= n_v1;
        r_s2_v2    <= n_v2;
        r_s2_v3    <= n_v3;
        r_s2_s     <= n_s;
        r_s2_np    <= n_np;
        r_s3_first <= r_s2_first;
        r_s3_pa    <= n_pa;
        r_s3_pb    <= n_pb;
        r_s3_nt    <= n_nt;
        r_s3_v1    <= r_s2_v1;
        r_s3_s     <= r_s2_s;
        r_s4_first <= r_s3_first;
        r_s4_dp    <= n_dp;
        r_s4_sp    <= n_sp;
        r_s5_first <= r_s4_first;
        r_s5_det   <= n_det;
        r_s5_neg   <= n_dot[DOT_W-1];
    end

    assign o_push            = r_valid[FRONT_STAGES-1];
    assign o_push_item.first = r_s5_first;
    assign o_push_item.sub   = r_s5_neg;
    assign o_push_item.clip  = n_over;
    assign o_push_item.term  = n_term;

endmodule

### hw/rtl/msva_back.sv
// ----------------------------------------------------------------------------
// msva_back: accumulation and division by six
// Takes classified terms from the queue, keeps the saturating running sum and
// divides a snapshot of it by six, one quotient octet per pipeline stage.
// ----------------------------------------------------------------------------
module msva_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  msva_pkg::t_term_item   i_head,
    input  msva_pkg::t_fifo_status i_fifo_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [msva_pkg::SUM_W-1:0] o_volume,
    output logic                   o_saturated
);
    import msva_pkg::*;

    logic                  n_adv;
    logic [SUM_W-1:0]      n_base;
    logic                  n_clip_base;
    logic [SUM_W:0]        n_ext;
    logic [SUM_W-1:0]      n_sum;
    logic                  n_sat;

    logic [SUM_W-1:0]      r_sum;
    logic                  r_clipped;
    logic                  r_a_valid;

    logic                  r_b_valid;
    logic [SUM_W-1:0]      r_b_work;
    logic                  r_b_neg;
    logic                  r_b_clip;

    logic [DIV_STAGES-1:0] r_d_valid;
    logic [SUM_W-1:0]      r_d_work [DIV_STAGES];
    logic [REM_W-1:0]      r_d_rem  [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_d_neg;
    logic [DIV_STAGES-1:0] r_d_clip;

    logic [DIV_STAGES:0]   w_valid;
    logic [SUM_W-1:0]      w_work [DIV_STAGES+1];
    logic [REM_W-1:0]      w_rem  [DIV_STAGES+1];
    logic [DIV_STAGES:0]   w_neg;
    logic [DIV_STAGES:0]   w_clip;
    logic [OCTET_W+REM_W-1:0] n_step [DIV_STAGES];

    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_volume;
    logic                  r_out_sat;

    // The whole back pipeline moves unless a finished result is held.
    assign n_adv = !(r_out_valid && i_out_stall);
    assign o_pop = n_adv && !i_fifo_status.empty;

    // Saturating add or subtract; one extra bit shows the overflow.
    always_comb begin
        n_base      = i_head.first ? '0 : r_sum;
        n_clip_base = i_head.first ? 1'b0 : r_clipped;
        if (i_head.sub) begin
            n_ext = {n_base[SUM_W-1], n_base} - {2'b00, i_head.term};
        end else begin
            n_ext = {n_base[SUM_W-1], n_base} + {2'b00, i_head.term};
        end
        n_sat = (n_ext[SUM_W] != n_ext[SUM_W-1]);
        if (n_sat) begin
            n_sum = {n_ext[SUM_W], {(SUM_W-1){!n_ext[SUM_W]}}};
        end else begin
            n_sum = n_ext[SUM_W-1:0];
        end
    end

    assign w_valid[0] = r_b_valid;
    assign w_work[0]  = r_b_work;
    assign w_rem[0]   = '0;
    assign w_neg[0]   = r_b_neg;
    assign w_clip[0]  = r_b_clip;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        assign n_step[k]    = div6_octet(w_rem[k], w_work[k][SUM_W-1 -: OCTET_W]);
        assign w_valid[k+1] = r_d_valid[k];
        assign w_work[k+1]  = r_d_work[k];
        assign w_rem[k+1]   = r_d_rem[k];
        assign w_neg[k+1]   = r_d_neg[k];
        assign w_clip[k+1]  = r_d_clip[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_clipped   <= 1'b0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_d_valid   <= '0;
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            if (o_pop) begin
                r_sum     <= n_sum;
                r_clipped <= n_clip_base | i_head.clip | n_sat;
            end
            r_a_valid   <= o_pop;
            r_b_valid   <= r_a_valid;
            r_d_valid   <= w_valid[DIV_STAGES-1:0];
            r_out_valid <= w_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_b_work <= r_sum[SUM_W-1] ? -r_sum : r_sum;
            r_b_neg  <= r_sum[SUM_W-1];
            r_b_clip <= r_clipped;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_d_work[k] <= {w_work[k][SUM_W-OCTET_W-1:0], n_step[k][OCTET_W+REM_W-1 -: OCTET_W]};
                r_d_rem[k]  <= n_step[k][REM_W-1:0];
                r_d_neg[k]  <= w_neg[k];
                r_d_clip[k] <= w_clip[k];
            end
            r_out_volume <= w_neg[DIV_STAGES] ? -w_work[DIV_STAGES] : w_work[DIV_STAGES];
            r_out_sat    <= w_clip[DIV_STAGES];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_volume    = r_out_volume;
    assign o_saturated = r_out_sat;

endmodule

### hw/rtl/mesh_signed_volume_accumulator_core.sv
// ----------------------------------------------------------------------------
// mesh_signed_volume_accumulator_core: running signed volume of a mesh
// Top level: world matrix registers, triangle front end, term queue and the
// accumulating back end.
// ----------------------------------------------------------------------------
// Usage. One input item is one triangle with its face normal; every item
// gives exactly one result item, the running volume (sum of six-volume terms
// divided by six, truncated toward zero, 24 fraction bits) and a sticky
// saturation flag. Raise first_of_mesh on the first triangle of a mesh to
// clear the sum and the flag before that triangle is added.
// Both item channels hand over on a rising edge with valid high and stall
// low. The three matrix rows are written through the configuration channel,
// which is always ready; an index beyond the third row is ignored. Rows
// should only be written while no item is in flight.
// An accepted item passes through five front stages, the queue,
// the accumulator, a magnitude stage, eight divide-by-six octet stages and
// the output register. One item is accepted per cycle while input stall is
// low; the single carried path is the saturating add in the back end.
// The front accepts an item only while the eight-entry queue has room for it
// and for everything already in the front pipeline. When the receiver
// stalls, the back end holds, the queue fills and input stall follows.
// Reset clears the sum, the flag and all valid state, and sets each matrix
// row to Q2.14 ones in its x and y entries and zero in its z entry.
// ----------------------------------------------------------------------------
module mesh_signed_volume_accumulator_core #(
    parameter int COORD_BITS          = 20,
    parameter int COORD_FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // triangle channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_first_of_mesh,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_a_x,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_a_y,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_a_z,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_b_x,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_b_y,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_b_z,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_c_x,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_c_y,
    input  logic signed [msva_pkg::COORD_W-1:0]   i_vertex_c_z,
    input  logic [msva_pkg::ROW_W-1:0]            i_face_normal,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [msva_pkg::SUM_W-1:0]     o_running_volume,
    output logic                                  o_saturated,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [msva_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [msva_pkg::ROW_W-1:0]            i_cfg_data
);
    import msva_pkg::*;

    t_matrix       r_matrix;
    t_triangle     w_tri;
    t_fifo_status  w_fifo_status;
    t_term_item    w_push_item;
    t_term_item    w_head;
    logic          w_push;
    logic          w_pop;
    logic [SUM_W-1:0] w_volume;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix.row_zero <= MATRIX_RESET;
            r_matrix.row_one  <= MATRIX_RESET;
            r_matrix.row_two  <= MATRIX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_ZERO: r_matrix.row_zero <= i_cfg_data;
                CFG_ROW_ONE:  r_matrix.row_one  <= i_cfg_data;
                CFG_ROW_TWO:  r_matrix.row_two  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Gather the triangle fields into one item for the front end.
    assign w_tri.first    = i_first_of_mesh;
    assign w_tri.coord[0] = i_vertex_a_x;
    assign w_tri.coord[1] = i_vertex_a_y;
    assign w_tri.coord[2] = i_vertex_a_z;
    assign w_tri.coord[3] = i_vertex_b_x;
    assign w_tri.coord[4] = i_vertex_b_y;
    assign w_tri.coord[5] = i_vertex_b_z;
    assign w_tri.coord[6] = i_vertex_c_x;
    assign w_tri.coord[7] = i_vertex_c_y;
    assign w_tri.coord[8] = i_vertex_c_z;
    assign w_tri.normal   = i_face_normal;

    msva_front #(
        .COORD_BITS          (COORD_BITS),
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_matrix      (r_matrix),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_tri         (w_tri),
        .i_fifo_status (w_fifo_status),
        .o_push        (w_push),
        .o_push_item   (w_push_item)
    );

    msva_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_fifo_status)
    );

    msva_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_fifo_status (w_fifo_status),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_volume      (w_volume),
        .o_saturated   (o_saturated)
    );

    assign o_running_volume = $signed(w_volume);

endmodule

### dv/msva_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msva_checker: result predictor and comparator for the volume accumulator
// Watches the triangle, result and register channels, keeps its own copy of
// the world matrix and the running six-volume sum, and compares every
// accepted result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module msva_checker #(
    parameter int COORD_BITS          = 20,
    parameter int COORD_FRACTION_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_first_of_mesh,
    input  logic [msva_pkg::NUM_COORDS-1:0][msva_pkg::COORD_W-1:0] i_coords,
    input  logic [msva_pkg::ROW_W-1:0]          i_face_normal,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [msva_pkg::SUM_W-1:0]          i_running_volume,
    input  logic                                i_saturated,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [msva_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [msva_pkg::ROW_W-1:0]          i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_results,
    output int                                  o_sub_terms,
    output int                                  o_sat_results
);
    import msva_pkg::*;

    localparam longint SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam int     MAG_FRAC  = 3 * COORD_FRACTION_BITS;

    typedef struct packed {
        logic [SUM_W-1:0] volume;
        logic             sat;
    } t_volume_result;

    t_row           world_row [3];
    longint         acc_sum;
    logic           acc_clipped;
    t_volume_result volume_queue [$];
    int             fail_count;
    int             results;
    int             sub_terms;
    int             sat_results;

    // Advances the accumulated sum by one triangle and returns the result
    // that the block must give for it.
    function automatic t_volume_result next_running_volume(
        input logic                                first,
        input logic [NUM_COORDS-1:0][COORD_W-1:0] c,
        input logic [ROW_W-1:0]                    nrm
    );
        longint         p [NUM_COORDS];
        longint         nv [3];
        longint         nt [3];
        longint         e1 [3];
        longint         e2 [3];
        longint         e3 [3];
        longint         s [3];
        longint         det;
        longint         dot;
        longint         term;
        logic [63:0]    mag;
        logic [63:0]    wide;
        t_volume_result r;
        int             i;
        int             j;

        if (first) begin
            acc_sum     = 0;
            acc_clipped = 1'b0;
        end
        // Only the low COORD_BITS bits of a coordinate count.
        for (i = 0; i < NUM_COORDS; i++) begin
            wide = 64'(c[i]) << (64 - COORD_BITS);
            p[i] = $signed(wide) >>> (64 - COORD_BITS);
        end
        for (j = 0; j < 3; j++) begin
            nv[j] = longint'($signed(nrm[NORM_W*j +: NORM_W]));
        end
        // Row vector times matrix.
        for (j = 0; j < 3; j++) begin
            nt[j] = 0;
            for (i = 0; i < 3; i++) begin
                nt[j] += nv[i] * longint'($signed(world_row[i][NORM_W*j +: NORM_W]));
            end
        end
        for (i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
            e3[i] = -p[i];
            s[i]  = p[i] + p[3+i] + p[6+i];
        end
        det = e1[0] * (e2[1] * e3[2] - e3[1] * e2[2])
            - e1[1] * (e2[0] * e3[2] - e3[0] * e2[2])
            + e1[2] * (e2[0] * e3[1] - e3[0] * e2[1]);
        mag = (det < 0) ? 64'(-det) : 64'(det);

        // Bring the magnitude to the fraction point of the sum.
        if (MAG_FRAC >= OUT_FRAC) begin
            mag = mag >> (MAG_FRAC - OUT_FRAC);
        end else if (mag > (64'(SUM_MAX) >> (OUT_FRAC - MAG_FRAC))) begin
            mag         = 64'(SUM_MAX);
            acc_clipped = 1'b1;
        end else begin
            mag = mag << (OUT_FRAC - MAG_FRAC);
        end
        term = longint'(mag);

        dot = nt[0] * s[0] + nt[1] * s[1] + nt[2] * s[2];
        if (dot >= 0) begin
            if (acc_sum > SUM_MAX - term) begin
                acc_sum     = SUM_MAX;
                acc_clipped = 1'b1;
            end else begin
                acc_sum += term;
            end
        end else begin
            sub_terms++;
            if (acc_sum < SUM_MIN + term) begin
                acc_sum     = SUM_MIN;
                acc_clipped = 1'b1;
            end else begin
                acc_sum -= term;
            end
        end

        r.volume = acc_sum / VOLUME_DIV;
        r.sat    = acc_clipped;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_volume_result want;

        if (!i_rst_n) begin
            world_row[0] = MATRIX_RESET;
            world_row[1] = MATRIX_RESET;
            world_row[2] = MATRIX_RESET;
            acc_sum      = 0;
            acc_clipped  = 1'b0;
            volume_queue.delete();
            fail_count   = 0;
            results      = 0;
            sub_terms    = 0;
            sat_results  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW_ZERO: world_row[0] = i_cfg_data;
                    CFG_ROW_ONE:  world_row[1] = i_cfg_data;
                    CFG_ROW_TWO:  world_row[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                volume_queue.push_back(
                    next_running_volume(i_first_of_mesh, i_coords, i_face_normal));
            end
            if (i_out_valid && !i_out_stall) begin
                if (volume_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no result, got volume %0d saturated %0b",
                             $time, $signed(i_running_volume), i_saturated);
                end else begin
                    want = volume_queue.pop_front();
                    results++;
                    if (want.sat) begin
                        sat_results++;
                    end
                    if (i_running_volume !== want.volume) begin
                        fail_count++;
                        $display("%0t: running_volume expected %0d got %0d", $time,
                                 $signed(want.volume), $signed(i_running_volume));
                    end
                    if (i_saturated !== want.sat) begin
                        fail_count++;
                        $display("%0t: saturated expected %0b got %0b", $time,
                                 want.sat, i_saturated);
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_pending     <= volume_queue.size();
        o_results     <= results;
        o_sub_terms   <= sub_terms;
        o_sat_results <= sat_results;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the mesh signed volume accumulator core
// Streams triangles through the block under several world matrices, with
// bursty input, a receiver that stalls on its own pattern and one long
// receiver hold-off, and leaves all prediction and comparison to the
// checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import msva_pkg::*;

    localparam int COORD_BITS          = 20;
    localparam int COORD_FRACTION_BITS = 8;

    // A generous settling margin, used after each drain and at the end of the run.
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD       = 200;
    localparam int HOLD_AFTER      = 150;

    // The register channel has four index codes but only three rows.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Q12.8 coordinates.
    localparam logic [COORD_W-1:0] C_MAX     = 20'h7FFFF;
    localparam logic [COORD_W-1:0] C_MIN     = 20'h80000;
    localparam logic [COORD_W-1:0] C_ONE     = 20'h00100;
    localparam logic [COORD_W-1:0] C_NEG_ONE = 20'hFFF00;

    // Packed normal lanes, Q1.14.
    localparam logic [ROW_W-1:0] NRM_PLUS   = 48'h4000_4000_4000;
    localparam logic [ROW_W-1:0] NRM_MINUS  = 48'hC000_C000_C000;
    localparam logic [ROW_W-1:0] NRM_MIXED  = 48'h7FFF_8000_7FFF;

    typedef enum int {
        SHAPE_TINY,
        SHAPE_MID,
        SHAPE_FULL,
        SHAPE_CORNER
    } t_shape;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                first_of_mesh;
    logic [NUM_COORDS-1:0][COORD_W-1:0] in_coords;
    logic [ROW_W-1:0]                    face_normal;
    logic                                out_valid;
    logic                                out_stall;
    logic [SUM_W-1:0]                    running_volume;
    logic                                saturated;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [CFG_IDX_W-1:0]                cfg_index;
    logic [ROW_W-1:0]                    cfg_data;

    int fail_count;
    int pending;
    int results;
    int sub_terms;
    int sat_results;
    int triangles_sent;
    int matrix_settings;
    int burst_left;

    always #5 clk = ~clk;

    mesh_signed_volume_accumulator_core #(
        .COORD_BITS          (COORD_BITS),
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_first_of_mesh  (first_of_mesh),
        .i_vertex_a_x     (in_coords[0]),
        .i_vertex_a_y     (in_coords[1]),
        .i_vertex_a_z     (in_coords[2]),
        .i_vertex_b_x     (in_coords[3]),
        .i_vertex_b_y     (in_coords[4]),
        .i_vertex_b_z     (in_coords[5]),
        .i_vertex_c_x     (in_coords[6]),
        .i_vertex_c_y     (in_coords[7]),
        .i_vertex_c_z     (in_coords[8]),
        .i_face_normal    (face_normal),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_running_volume (running_volume),
        .o_saturated      (saturated),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    msva_checker #(
        .COORD_BITS          (COORD_BITS),
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_first_of_mesh  (first_of_mesh),
        .i_coords         (in_coords),
        .i_face_normal    (face_normal),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_running_volume (running_volume),
        .i_saturated      (saturated),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results        (results),
        .o_sub_terms      (sub_terms),
        .o_sat_results    (sat_results)
    );

    // ------------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------------

    // One coordinate of the requested spread. Full-range values exercise
    // every bit of the field; corner values hit the representable limits.
    function automatic logic [COORD_W-1:0] rand_coord(input t_shape shp);
        int v;
        case (shp)
            SHAPE_TINY: v = $urandom_range(8191) - 4096;
            SHAPE_MID:  v = $urandom_range(131071) - 65536;
            SHAPE_FULL: v = $urandom;
            default: begin
                case ($urandom_range(4))
                    0:       v = int'($signed(C_MAX));
                    1:       v = int'($signed(C_MIN));
                    2:       v = 0;
                    3:       v = 1;
                    default: v = -1;
                endcase
            end
        endcase
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [NUM_COORDS-1:0][COORD_W-1:0] rand_corners(input t_shape shp);
        logic [NUM_COORDS-1:0][COORD_W-1:0] c;
        for (int i = 0; i < NUM_COORDS; i++) begin
            c[i] = rand_coord(shp);
        end
        return c;
    endfunction

    // A fully random normal most of the time; otherwise lanes are picked
    // from unit, negative unit, the lane limits and zero, which makes a zero
    // dot product (and so the add path) reasonably common.
    function automatic logic [ROW_W-1:0] rand_normal();
        logic [ROW_W-1:0] n;
        n = {16'($urandom), 32'($urandom)};
        if ($urandom_range(9) < 4) begin
            for (int j = 0; j < 3; j++) begin
                case ($urandom_range(4))
                    0:       n[NORM_W*j +: NORM_W] = 16'h4000;
                    1:       n[NORM_W*j +: NORM_W] = 16'hC000;
                    2:       n[NORM_W*j +: NORM_W] = 16'h7FFF;
                    3:       n[NORM_W*j +: NORM_W] = 16'h8000;
                    default: n[NORM_W*j +: NORM_W] = 16'h0000;
                endcase
            end
        end
        return n;
    endfunction

    // A triangle close to the largest possible determinant, about 2^59 in
    // the sum's units: seventeen in a row with one sign overflow the sum.
    // Mirroring through the origin keeps the size but flips the sign test.
    function automatic logic [NUM_COORDS-1:0][COORD_W-1:0] huge_corners(input bit mirror);
        logic [NUM_COORDS-1:0][COORD_W-1:0] c;
        logic [COORD_W-1:0]                 lo;
        logic [COORD_W-1:0]                 hi;
        lo   = mirror ? C_MAX : C_MIN;
        hi   = mirror ? C_MIN : C_MAX;
        c    = {NUM_COORDS{lo}};
        c[4] = hi;
        c[8] = hi;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offers one triangle and returns once it has been taken. The sender
    // works in bursts; between bursts valid drops for a random gap, and some
    // bursts follow with no gap at all.
    task automatic send_triangle(
        input logic                                first,
        input logic [NUM_COORDS-1:0][COORD_W-1:0] c,
        input logic [ROW_W-1:0]                    nrm
    );
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid      = 1'b1;
        first_of_mesh = first;
        in_coords     = c;
        face_normal   = nrm;
        do @(posedge clk); while (in_stall);
        triangles_sent++;
    endtask

    // Stops offering and waits until every predicted result has been seen,
    // then lets the pipeline settle before any register is touched.
    task automatic drain_results();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_matrix(input t_row r0, input t_row r1, input t_row r2);
        write_row(CFG_ROW_ZERO, r0);
        write_row(CFG_ROW_ONE, r1);
        write_row(CFG_ROW_TWO, r2);
        matrix_settings++;
    endtask

    // Random part of a phase. Most of it is meshes: a clearing triangle then
    // a run sharing one spread. Some runs are overflow meshes of huge
    // triangles with one normal, and the rest are stray triangles with
    // random mesh starts.
    task automatic random_meshes(input int count);
        int                                 done;
        int                                 len;
        int                                 pick;
        bit                                 mirror;
        t_shape                             shp;
        logic [ROW_W-1:0]                   nrm;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                len    = $urandom_range(17, 20);
                nrm    = rand_normal();
                mirror = 1'($urandom_range(1));
                for (int i = 0; i < len; i++) begin
                    send_triangle(i == 0, huge_corners(mirror), nrm);
                end
            end else if (pick < 24) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    send_triangle(1'($urandom_range(1)),
                                  rand_corners(t_shape'($urandom_range(3))),
                                  rand_normal());
                end
            end else begin
                len = $urandom_range(1, 12);
                shp = t_shape'($urandom_range(3));
                for (int i = 0; i < len; i++) begin
                    send_triangle(i == 0, rand_corners(shp), rand_normal());
                end
            end
            done += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: its stall pattern switches between never, light, heavy and
    // periodic. Once, well into the run, it holds off for a long stretch while
    // the sender keeps offering, so the queue fills and the block has to stall
    // its input.
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int cyc;
        bit hold_done;
        out_stall = 1'b0;
        mode      = 0;
        cyc       = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && results >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (cyc % 64 == 0) begin
                mode = $urandom_range(3);
            end
            case (mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(3) == 0);
                2:       out_stall = ($urandom_range(3) != 0);
                default: out_stall = (cyc % 5 < 2);
            endcase
            cyc++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no channel moves an item for too long.
    // ------------------------------------------------------------------------
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
                (cfg_valid && cfg_ready === 1'b1)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Timeout: %0d cycles without a handshake, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [NUM_COORDS-1:0][COORD_W-1:0] corners;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        first_of_mesh   = 1'b0;
        in_coords       = '0;
        face_normal     = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_ROW_ZERO;
        cfg_data        = '0;
        triangles_sent  = 0;
        matrix_settings = 1;
        burst_left      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Registers change only with the block empty.
            if (ph > 0) begin
                drain_results();
            end
            case (ph)
                1: set_matrix(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
                2: set_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
                // A zero matrix makes every dot product zero, so all terms add.
                3: set_matrix('0, '0, '0);
                4: begin
                    set_matrix(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000);
                    // A write to the unused index must leave the matrix alone.
                    write_row(CFG_IDX_SPARE, {16'($urandom), 32'($urandom)});
                end
                5: set_matrix({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                              {16'($urandom), 32'($urandom)});
                default: ;
            endcase

            if (ph == 0) begin
                // Directed triangles under the reset matrix. A degenerate
                // triangle with a zero normal opens the mesh.
                corners = '0;
                send_triangle(1'b1, corners, '0);
                // Unit triangle off the origin: positive normal, negative
                // normal and a zero normal, which must take the add path.
                corners[0] = C_ONE;
                corners[4] = C_ONE;
                corners[8] = C_ONE;
                send_triangle(1'b0, corners, NRM_PLUS);
                send_triangle(1'b0, corners, NRM_MINUS);
                send_triangle(1'b0, corners, '0);
                // Coordinates and normal lanes at their limits.
                corners[0] = C_MAX;
                corners[1] = C_MAX;
                corners[2] = C_MAX;
                corners[3] = C_MIN;
                corners[4] = C_MIN;
                corners[5] = C_MIN;
                corners[6] = C_MAX;
                corners[7] = C_MIN;
                corners[8] = '0;
                send_triangle(1'b0, corners, NRM_MIXED);
                // Vertices summing to zero, so the sign test sees zero.
                corners    = '0;
                corners[0] = C_ONE;
                corners[4] = C_ONE;
                corners[6] = C_NEG_ONE;
                corners[7] = C_NEG_ONE;
                send_triangle(1'b0, corners, rand_normal());
                // Enough huge terms of one sign to pin the sum at its limit,
                // then a new mesh that must clear the flag again.
                for (int i = 0; i < 17; i++) begin
                    send_triangle(i == 0, huge_corners(1'b0), NRM_MINUS);
                end
                send_triangle(1'b1, huge_corners(1'b1), NRM_PLUS);
            end

            random_meshes(ITEMS_PER_PHASE);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d triangles and %0d results under %0d matrix settings.",
                 triangles_sent, results, matrix_settings);
        $display("Of those, %0d terms were subtracted and %0d results showed saturation.",
                 sub_terms, sat_results);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
